FILE: hw/rtl/ps2sa_pkg.sv
// Shared types, codes and the set-1 keymap for the scancode-to-ASCII FIFO.
package ps2sa_pkg;

   // Request operation codes.
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Set-1 scancodes of interest.
   localparam logic [7:0] SC_LSHIFT = 8'h2A;
   localparam logic [7:0] SC_RSHIFT = 8'h36;
   localparam logic [7:0] SC_BREAK  = 8'h80;
   localparam logic [7:0] TABLE_LEN = 8'd59;

   typedef logic [6:0] char_type;

   // Result flags carried through the output stages.
   typedef struct packed {
      logic char_valid;
      logic nonempty;
      logic dropped;
   } rsp_flags_type;

   // US keymap: returns the plain or shifted character for a make code below 59.
   // Zero means the key produces no character.
   function automatic char_type map_char(input logic [5:0] idx, input logic shifted);
      logic [13:0] pr;
      begin
         case (idx)
            6'd2:    pr = {7'h31, 7'h21};
            6'd3:    pr = {7'h32, 7'h40};
            6'd4:    pr = {7'h33, 7'h23};
            6'd5:    pr = {7'h34, 7'h24};
            6'd6:    pr = {7'h35, 7'h25};
            6'd7:    pr = {7'h36, 7'h5E};
            6'd8:    pr = {7'h37, 7'h26};
            6'd9:    pr = {7'h38, 7'h2A};
            6'd10:   pr = {7'h39, 7'h28};
            6'd11:   pr = {7'h30, 7'h29};
            6'd12:   pr = {7'h2D, 7'h5F};
            6'd13:   pr = {7'h3D, 7'h2B};
            6'd14:   pr = {7'h08, 7'h08};
            6'd15:   pr = {7'h09, 7'h09};
            6'd16:   pr = {7'h71, 7'h51};
            6'd17:   pr = {7'h77, 7'h57};
            6'd18:   pr = {7'h65, 7'h45};
            6'd19:   pr = {7'h72, 7'h52};
            6'd20:   pr = {7'h74, 7'h54};
            6'd21:   pr = {7'h79, 7'h59};
            6'd22:   pr = {7'h75, 7'h55};
            6'd23:   pr = {7'h69, 7'h49};
            6'd24:   pr = {7'h6F, 7'h4F};
            6'd25:   pr = {7'h70, 7'h50};
            6'd26:   pr = {7'h5B, 7'h7B};
            6'd27:   pr = {7'h5D, 7'h7D};
            6'd28:   pr = {7'h0A, 7'h0A};
            6'd30:   pr = {7'h61, 7'h41};
            6'd31:   pr = {7'h73, 7'h53};
            6'd32:   pr = {7'h64, 7'h44};
            6'd33:   pr = {7'h66, 7'h46};
            6'd34:   pr = {7'h67, 7'h47};
            6'd35:   pr = {7'h68, 7'h48};
            6'd36:   pr = {7'h6A, 7'h4A};
            6'd37:   pr = {7'h6B, 7'h4B};
            6'd38:   pr = {7'h6C, 7'h4C};
            6'd39:   pr = {7'h3B, 7'h3A};
            6'd40:   pr = {7'h27, 7'h22};
            6'd41:   pr = {7'h60, 7'h7E};
            6'd43:   pr = {7'h5C, 7'h7C};
            6'd44:   pr = {7'h7A, 7'h5A};
            6'd45:   pr = {7'h78, 7'h58};
            6'd46:   pr = {7'h63, 7'h43};
            6'd47:   pr = {7'h76, 7'h56};
            6'd48:   pr = {7'h62, 7'h42};
            6'd49:   pr = {7'h6E, 7'h4E};
            6'd50:   pr = {7'h6D, 7'h4D};
            6'd51:   pr = {7'h2C, 7'h3C};
            6'd52:   pr = {7'h2E, 7'h3E};
            6'd53:   pr = {7'h2F, 7'h3F};
            6'd55:   pr = {7'h2A, 7'h2A};
            6'd57:   pr = {7'h20, 7'h20};
            default: pr = 14'h0000;
         endcase
         return shifted ? pr[6:0] : pr[13:7];
      end
   endfunction

endpackage

FILE: hw/rtl/ps2_scancode_to_ascii_fifo_top.sv
// Top level of the PS/2 set-1 scancode to ASCII translator with a character FIFO.
//
// Requests arrive on the req_ channel: req_op selects a scancode byte (req_scancode)
// or a read of one character. Each request yields exactly one response on the rsp_
// channel, in order. Shift make/break codes track the shift state; other make codes
// below 59 are translated and pushed into a ring FIFO of FIFO_DEPTH entries that
// holds at most FIFO_DEPTH-1 characters. A full FIFO drops the character and sets
// rsp_dropped. A read pops the oldest character, or reports rsp_char_valid low.
// Every response reports rsp_nonempty after that request.
//
// rsp_valid rises in the cycle after acceptance: the character store is a
// synchronous memory whose registered read port forms the output stage. One
// request is accepted every cycle while req_stall is low; each touches the memory at most once.
// When rsp_stall is held, one further request is still accepted while the stalled
// response moves into a skid register, after which req_stall rises until the skid
// register drains. At most two responses are held at any time.
// Reset clears the shift state, both pointers and all valid flags; the store
// itself is not cleared and needs no clearing pass.
module ps2_scancode_to_ascii_fifo_top
   import ps2sa_pkg::*;
#(
   parameter int FIFO_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_scancode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_char_valid,
   output logic [6:0] rsp_char_out,
   output logic       rsp_nonempty,
   output logic       rsp_dropped
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   // Control and pointer state.
   logic             shift_ff, shift_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             s1_valid_ff, s1_valid_in;
   rsp_flags_type    s1_flags_ff, s1_flags_in;
   logic             skid_valid_ff, skid_valid_in;
   rsp_flags_type    skid_flags_ff;
   char_type         skid_char_ff;

   // Character store and its registered read port.
   char_type         mem [FIFO_DEPTH];
   char_type         rd_data_ff;

   logic             req_accept;
   logic             s1_take;
   logic             is_read;
   logic             is_shift_make;
   logic             is_shift_break;
   logic             table_hit;
   char_type         map_out;
   logic             push_try;
   logic             fifo_full;
   logic             do_push;
   logic             do_pop;
   logic [PTR_W-1:0] wr_inc;
   logic [PTR_W-1:0] rd_inc;
   char_type         s1_char;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   // Request decode and FIFO pointer arithmetic.
   always_comb begin
      is_read        = (req_op == OP_READ);
      is_shift_make  = (req_scancode == SC_LSHIFT) || (req_scancode == SC_RSHIFT);
      is_shift_break = (req_scancode == (SC_LSHIFT | SC_BREAK))
                    || (req_scancode == (SC_RSHIFT | SC_BREAK));
      table_hit      = !is_read && !is_shift_make && !is_shift_break
                    && (req_scancode < TABLE_LEN);
      map_out        = map_char(req_scancode[5:0], shift_ff);
      push_try       = table_hit && (map_out != 7'd0);
      wr_inc         = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      rd_inc         = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      fifo_full      = (wr_inc == rd_ptr_ff);
      do_push        = req_accept && push_try && !fifo_full;
      do_pop         = req_accept && is_read && (wr_ptr_ff != rd_ptr_ff);
   end

   // Next state of the shift flag and the pointers.
   always_comb begin
      shift_in  = shift_ff;
      wr_ptr_in = do_push ? wr_inc : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_inc : rd_ptr_ff;
      if (req_accept && !is_read) begin
         if (is_shift_make) begin
            shift_in = 1'b1;
         end else if (is_shift_break) begin
            shift_in = 1'b0;
         end
      end
   end

   // Flags for the response of the request being accepted.
   always_comb begin
      s1_flags_in.char_valid = do_pop;
      s1_flags_in.nonempty   = (wr_ptr_in != rd_ptr_in);
      s1_flags_in.dropped    = push_try && fifo_full;
   end

   // Output stage and skid register hand-off.
   assign s1_take = s1_valid_ff && !skid_valid_ff && !rsp_stall;
   assign s1_char = s1_flags_ff.char_valid ? rd_data_ff : 7'd0;

   always_comb begin
      s1_valid_in   = req_accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         skid_valid_in = rsp_stall;
      end else if (s1_valid_ff && rsp_stall && req_accept) begin
         skid_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         s1_valid_ff   <= s1_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flags_ff <= s1_flags_in;
      end
      if (!skid_valid_ff && s1_valid_ff && rsp_stall && req_accept) begin
         skid_flags_ff <= s1_flags_ff;
         skid_char_ff  <= s1_char;
      end
   end

   // Character store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= map_out;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // Response port: the skid register is older and goes first.
   assign rsp_valid      = skid_valid_ff || s1_valid_ff;
   assign rsp_char_valid = skid_valid_ff ? skid_flags_ff.char_valid : s1_flags_ff.char_valid;
   assign rsp_char_out   = skid_valid_ff ? skid_char_ff : s1_char;
   assign rsp_nonempty   = skid_valid_ff ? skid_flags_ff.nonempty : s1_flags_ff.nonempty;
   assign rsp_dropped    = skid_valid_ff ? skid_flags_ff.dropped : s1_flags_ff.dropped;

   // The skid register only ever holds the older of two pending responses.
   a_skid_has_s1: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> s1_valid_ff)
      else $error("skid register valid without a pending output stage");

   // Pointers stay inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_LAST) && (rd_ptr_ff <= PTR_LAST))
      else $error("FIFO pointer out of range");

   // A read of an empty FIFO never returns a character.
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_read && (wr_ptr_ff == rd_ptr_ff)) |=> !s1_flags_ff.char_valid)
      else $error("read of empty FIFO returned a character");

   // A response never both pops and drops.
   a_pop_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_char_valid && rsp_dropped))
      else $error("response both returns and drops a character");

   // A successful push always leaves the FIFO non-empty.
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_push |=> (wr_ptr_ff != rd_ptr_ff))
      else $error("FIFO empty after a push");

endmodule
